### rtl/core/otcs_pkg.sv
// Package for the owner-tracked counting semaphore.
// Holds opcodes, status codes, the default table depth and controller/datapath types.
// No dependencies.
package otcs_pkg;

    localparam int OTCS_SLOTS = 16;

    localparam int OP_W     = 2;
    localparam int OWNER_W  = 16;
    localparam int UNITS_W  = 16;
    localparam int STATUS_W = 3;
    localparam int DEATH_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE  = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_DOWN     = 2'd2,
        OP_RESERVED = 2'd3
    } otcs_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_NOT_FOUND    = 3'd2,
        ST_TABLE_FULL   = 3'd3,
        ST_OVER_RELEASE = 3'd4
    } otcs_status_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
    } otcs_cmd_t;

    typedef struct packed {
        logic scan_last;
    } otcs_sts_t;

endpackage

### rtl/core/otcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module otcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/otcs_ctrl.sv
// Controller for the owner-tracked counting semaphore.
// Sequences load, table scan, drain and decide; depends on otcs_pkg.
module otcs_ctrl
    import otcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  otcs_sts_t  sts,
    output otcs_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    busy_next  = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.decide = (state_reg == S_DECIDE);
    assign busy       = busy_reg;

    a_busy_track: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with controller state");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && sts.scan_last |=> (state_reg == S_DRAIN))
        else $error("scan did not end on last slot");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SCAN) && busy_reg)
        else $error("transfer accepted without starting scan");

endmodule

### rtl/core/otcs_dp.sv
// Datapath for the owner-tracked counting semaphore: counters, valid bits, scan and update.
// Depends on otcs_pkg and otcs_ram.
module otcs_dp
    import otcs_pkg::*;
#(
    parameter int OWNER_SLOTS = OTCS_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  otcs_cmd_t           cmd,
    output otcs_sts_t           sts,
    input  logic                capacity_limit_we,
    input  logic [UNITS_W-1:0]  capacity_limit,
    input  logic [OP_W-1:0]     opcode,
    input  logic [OWNER_W-1:0]  owner_id,
    input  logic [UNITS_W-1:0]  units,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [UNITS_W-1:0]  total_held,
    output logic [DEATH_W-1:0]  deaths_seen
);

    localparam int IW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int EW = OWNER_W + UNITS_W;

    // item registers
    logic [OP_W-1:0]    op_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [UNITS_W-1:0] units_reg;

    // control state
    logic [UNITS_W-1:0]     cap_reg;
    logic [UNITS_W-1:0]     total_reg, total_next;
    logic [DEATH_W-1:0]     death_reg, death_next;
    logic [OWNER_SLOTS-1:0] valid_reg, valid_next;
    logic [IW-1:0]          scan_reg;
    logic                   cmp_live_reg;
    logic [IW-1:0]          cmp_idx_reg;
    logic                   hit_reg;
    logic [IW-1:0]          hit_slot_reg;
    logic [UNITS_W-1:0]     held_reg;
    logic                   free_reg;
    logic [IW-1:0]          free_slot_reg;
    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // table
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [EW-1:0]      ram_rdata;
    logic [OWNER_W-1:0] rd_owner;
    logic [UNITS_W-1:0] rd_units;
    logic               match;

    otcs_ram #(
        .WIDTH (EW),
        .DEPTH (OWNER_SLOTS),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign rd_owner      = ram_rdata[EW-1:UNITS_W];
    assign rd_units      = ram_rdata[UNITS_W-1:0];
    assign match         = cmp_live_reg && valid_reg[cmp_idx_reg] && !hit_reg
                           && (rd_owner == owner_reg);
    assign sts.scan_last = (scan_reg == IW'(OWNER_SLOTS - 1));

    // decide
    always_comb
    begin
        logic [UNITS_W:0] sum_w;
        sum_w       = {1'b0, total_reg} + {1'b0, units_reg};
        total_next  = total_reg;
        death_next  = death_reg;
        valid_next  = valid_reg;
        status_next = ST_OK;
        ram_we      = 1'b0;
        ram_waddr   = hit_slot_reg;
        ram_wdata   = {owner_reg, held_reg + units_reg};
        case (op_reg)
            OP_ACQUIRE:
            begin
                if (units_reg == '0)
                begin
                    status_next = ST_OK;
                end
                else if (sum_w > {1'b0, cap_reg})
                begin
                    status_next = ST_FULL;
                end
                else if (hit_reg)
                begin
                    ram_we     = 1'b1;
                    total_next = sum_w[UNITS_W-1:0];
                end
                else if (free_reg)
                begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = free_slot_reg;
                    ram_wdata                 = {owner_reg, units_reg};
                    valid_next[free_slot_reg] = 1'b1;
                    total_next                = sum_w[UNITS_W-1:0];
                end
                else
                begin
                    status_next = ST_TABLE_FULL;
                end
            end
            OP_RELEASE:
            begin
                if (units_reg == '0)
                begin
                    status_next = ST_OK;
                end
                else if (!hit_reg)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (units_reg > held_reg)
                begin
                    status_next = ST_OVER_RELEASE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {owner_reg, held_reg - units_reg};
                    total_next = total_reg - units_reg;
                    if (held_reg == units_reg)
                    begin
                        valid_next[hit_slot_reg] = 1'b0;
                    end
                end
            end
            OP_DOWN:
            begin
                if (hit_reg)
                begin
                    total_next = (held_reg > total_reg) ? '0 : (total_reg - held_reg);
                    valid_next[hit_slot_reg] = 1'b0;
                end
                death_next = death_reg + 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (!cmd.decide)
        begin
            ram_we     = 1'b0;
            total_next = total_reg;
            death_next = death_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= '0;
            total_reg    <= '0;
            death_reg    <= '0;
            valid_reg    <= '0;
            scan_reg     <= '0;
            cmp_live_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (capacity_limit_we)
            begin
                cap_reg <= capacity_limit;
            end
            total_reg    <= total_next;
            death_reg    <= death_next;
            valid_reg    <= valid_next;
            cmp_live_reg <= cmd.scan;
            done_reg     <= cmd.decide;
            if (cmd.decide)
            begin
                status_reg <= status_next;
            end
            if (cmd.load)
            begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !sts.scan_last)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmd.scan && !free_reg && !valid_reg[scan_reg])
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            owner_reg <= owner_id;
            units_reg <= units;
        end
        cmp_idx_reg <= scan_reg;
        if (match)
        begin
            hit_slot_reg <= cmp_idx_reg;
            held_reg     <= rd_units;
        end
        if (cmd.scan && !free_reg && !valid_reg[scan_reg])
        begin
            free_slot_reg <= scan_reg;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign total_held  = total_reg;
    assign deaths_seen = death_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> done_reg)
        else $error("result strobe missing after decide");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg <= ST_OVER_RELEASE))
        else $error("status code out of range");

    a_death_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && (op_reg == OP_DOWN) |=> death_reg == $past(death_reg) + 1'b1)
        else $error("death count did not advance");

    a_quiet_total: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.decide |=> $stable(total_reg) && $stable(valid_reg))
        else $error("state changed outside decide");

endmodule

### rtl/core/owner_tracked_counting_semaphore_top.sv
// Top level of the owner-tracked counting semaphore.
// Depends on otcs_pkg, otcs_ctrl, otcs_dp and otcs_ram.
//
// Usage:
//   Commands: drive opcode, owner_id and units with start high; the transfer
//   is taken at a clock edge where busy is low. busy rises on the next cycle
//   and stays high while the owner table is scanned.
//   Results: done is high for one cycle with status, total_held and
//   deaths_seen valid. The receiver cannot stall; the result is taken then.
//   Sequence: the accepting edge starts the scan, which reads one table slot per
//   cycle from the owner RAM, followed by a drain state and a decide state;
//   done is registered from the decide state.
//   Back-to-back: a new command may be accepted in the cycle done is high;
//   none is taken while busy is high.
//   Configuration: capacity_limit is written when capacity_limit_we is high;
//   write only while idle.
//   Reset: table empty, capacity 0, total and death count zero; the owner RAM
//   is not cleared, as only slots marked valid can match.
module owner_tracked_counting_semaphore_top
    import otcs_pkg::*;
#(
    parameter int OWNER_SLOTS = OTCS_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     opcode,
    input  logic [OWNER_W-1:0]  owner_id,
    input  logic [UNITS_W-1:0]  units,
    input  logic                capacity_limit_we,
    input  logic [UNITS_W-1:0]  capacity_limit,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [UNITS_W-1:0]  total_held,
    output logic [DEATH_W-1:0]  deaths_seen
);

    otcs_cmd_t cmd;
    otcs_sts_t sts;

    otcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    otcs_dp #(
        .OWNER_SLOTS (OWNER_SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .capacity_limit_we (capacity_limit_we),
        .capacity_limit    (capacity_limit),
        .opcode            (opcode),
        .owner_id          (owner_id),
        .units             (units),
        .done              (done),
        .status            (status),
        .total_held        (total_held),
        .deaths_seen       (deaths_seen)
    );

endmodule
